// ===== sv/pts_pkg.sv =====
// Shared types, constants and character-class helpers for the PDF token scanner.
// Used by pts_step and pdf_token_scanner_core; depends on nothing else.
`default_nettype none

package pts_pkg;

  localparam int MAX_PAREN_DEPTH = 255;
  localparam int DEPTH_W         = $clog2(MAX_PAREN_DEPTH + 1);
  localparam int POS_W           = 32;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int MAX_RES         = 3;
  localparam int RCNT_W          = $clog2(MAX_RES + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_NAME,
    MODE_NUMBER,
    MODE_KEYWORD,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_LT,
    MODE_HEX,
    MODE_GT,
    MODE_DEAD
  } mode_t;

  typedef enum logic [3:0] {
    KIND_END,
    KIND_BAD,
    KIND_KEYWORD,
    KIND_NAME,
    KIND_STRING,
    KIND_HEX,
    KIND_NUMBER,
    KIND_LBRACK,
    KIND_RBRACK,
    KIND_DICT_OPEN,
    KIND_DICT_CLOSE
  } kind_t;

  typedef struct packed {
    mode_t              mode;
    logic [DEPTH_W-1:0] depth;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   start;
  } scan_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] start;
    logic [31:0] length;
    logic        last;
  } result_t;

  function automatic logic is_ws(input logic [7:0] b);
    return b inside {CH_NUL, CH_TAB, CH_LF, CH_FF, CH_CR, CH_SPACE};
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    return b inside {CH_LPAREN, CH_RPAREN, CH_LT, CH_GT, CH_LBRACK, CH_RBRACK,
                     CH_LBRACE, CH_RBRACE, CH_SLASH, CH_PCT};
  endfunction

  function automatic logic is_num(input logic [7:0] b);
    return (b inside {[CH_ZERO:CH_NINE]}) || b == CH_PLUS || b == CH_MINUS || b == CH_DOT;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pts_step.sv =====
// Combinational scanner step: from the current state and one byte, the next state
// and up to three token records. Depends on pts_pkg.
`default_nettype none

module pts_step (
  input  pts_pkg::scan_state_t                  state_in,
  input  logic [7:0]                            data_byte,
  input  logic                                  end_of_input,
  output pts_pkg::scan_state_t                  state_out,
  output pts_pkg::result_t [pts_pkg::MAX_RES-1:0] res,
  output logic [pts_pkg::RCNT_W-1:0]            res_cnt
);

  pts_pkg::mode_t                m;
  logic [pts_pkg::DEPTH_W-1:0]   d;
  logic [pts_pkg::POS_W-1:0]     s;
  logic [pts_pkg::POS_W-1:0]     p;
  logic [pts_pkg::POS_W-1:0]     q;
  logic [pts_pkg::POS_W-1:0]     np;
  logic                          go_idle;
  pts_pkg::result_t              cand [4];
  logic [3:0]                    cval;
  logic [pts_pkg::RCNT_W-1:0]    n;

  always_comb begin
    m       = state_in.mode;
    d       = state_in.depth;
    s       = state_in.start;
    p       = state_in.pos;
    q       = p + 1'b1;
    np      = q;
    go_idle = 1'b0;
    cval    = '0;
    for (int k = 0; k < 4; k++) begin
      cand[k] = '{kind: pts_pkg::KIND_END, start: '0, length: '0, last: 1'b0};
    end

    case (state_in.mode)
      pts_pkg::MODE_IDLE: begin
        go_idle = 1'b1;
      end
      pts_pkg::MODE_COMMENT: begin
        if (data_byte == pts_pkg::CH_LF || data_byte == pts_pkg::CH_CR) begin
          m = pts_pkg::MODE_IDLE;
        end
      end
      pts_pkg::MODE_NAME, pts_pkg::MODE_KEYWORD: begin
        if (pts_pkg::is_ws(data_byte) || pts_pkg::is_delim(data_byte)) begin
          cval[0] = 1'b1;
          cand[0].kind = (state_in.mode == pts_pkg::MODE_NAME) ? pts_pkg::KIND_NAME
                                                                : pts_pkg::KIND_KEYWORD;
          cand[0].start  = s;
          cand[0].length = p - s;
          m       = pts_pkg::MODE_IDLE;
          go_idle = 1'b1;
        end
      end
      pts_pkg::MODE_NUMBER: begin
        if (!pts_pkg::is_num(data_byte)) begin
          cval[0]        = 1'b1;
          cand[0].kind   = pts_pkg::KIND_NUMBER;
          cand[0].start  = s;
          cand[0].length = p - s;
          m       = pts_pkg::MODE_IDLE;
          go_idle = 1'b1;
        end
      end
      pts_pkg::MODE_STRING: begin
        if (data_byte == pts_pkg::CH_LPAREN) begin
          if (d >= pts_pkg::DEPTH_W'(pts_pkg::MAX_PAREN_DEPTH)) begin
            cval[1]        = 1'b1;
            cand[1].kind   = pts_pkg::KIND_BAD;
            cand[1].start  = p;
            cand[1].length = 32'd1;
            m = pts_pkg::MODE_DEAD;
            d = '0;
          end else begin
            d = d + 1'b1;
          end
        end else if (data_byte == pts_pkg::CH_RPAREN) begin
          if (d != '0) begin
            d = d - 1'b1;
          end
          if (d == '0) begin
            cval[0]        = 1'b1;
            cand[0].kind   = pts_pkg::KIND_STRING;
            cand[0].start  = s;
            cand[0].length = p - s;
            m = pts_pkg::MODE_IDLE;
          end
        end else if (data_byte == pts_pkg::CH_BSLASH) begin
          m = pts_pkg::MODE_ESCAPE;
        end
      end
      pts_pkg::MODE_ESCAPE: begin
        m = pts_pkg::MODE_STRING;
      end
      pts_pkg::MODE_LT: begin
        if (data_byte == pts_pkg::CH_LT) begin
          cval[0]        = 1'b1;
          cand[0].kind   = pts_pkg::KIND_DICT_OPEN;
          cand[0].start  = s;
          cand[0].length = 32'd2;
          m = pts_pkg::MODE_IDLE;
        end else if (data_byte == pts_pkg::CH_GT) begin
          cval[0]        = 1'b1;
          cand[0].kind   = pts_pkg::KIND_HEX;
          cand[0].start  = p;
          cand[0].length = 32'd0;
          m = pts_pkg::MODE_IDLE;
        end else begin
          s = p;
          m = pts_pkg::MODE_HEX;
        end
      end
      pts_pkg::MODE_HEX: begin
        if (data_byte == pts_pkg::CH_GT) begin
          cval[0]        = 1'b1;
          cand[0].kind   = pts_pkg::KIND_HEX;
          cand[0].start  = s;
          cand[0].length = p - s;
          m = pts_pkg::MODE_IDLE;
        end
      end
      pts_pkg::MODE_GT: begin
        cval[0]        = 1'b1;
        cand[0].start  = s;
        if (data_byte == pts_pkg::CH_GT) begin
          cand[0].kind   = pts_pkg::KIND_DICT_CLOSE;
          cand[0].length = 32'd2;
          m = pts_pkg::MODE_IDLE;
        end else begin
          cand[0].kind   = pts_pkg::KIND_BAD;
          cand[0].length = 32'd1;
          m = pts_pkg::MODE_DEAD;
          d = '0;
        end
      end
      default: begin
        m = pts_pkg::MODE_DEAD;
      end
    endcase

    if (go_idle && !pts_pkg::is_ws(data_byte)) begin
      s = p;
      case (data_byte)
        pts_pkg::CH_PCT: m = pts_pkg::MODE_COMMENT;
        pts_pkg::CH_SLASH: begin
          m = pts_pkg::MODE_NAME;
          s = q;
        end
        pts_pkg::CH_LPAREN: begin
          m = pts_pkg::MODE_STRING;
          d = pts_pkg::DEPTH_W'(1);
          s = q;
        end
        pts_pkg::CH_LT: m = pts_pkg::MODE_LT;
        pts_pkg::CH_GT: m = pts_pkg::MODE_GT;
        pts_pkg::CH_LBRACK, pts_pkg::CH_RBRACK: begin
          cval[1]        = 1'b1;
          cand[1].kind   = (data_byte == pts_pkg::CH_LBRACK) ? pts_pkg::KIND_LBRACK
                                                             : pts_pkg::KIND_RBRACK;
          cand[1].start  = p;
          cand[1].length = 32'd1;
        end
        pts_pkg::CH_RPAREN, pts_pkg::CH_LBRACE, pts_pkg::CH_RBRACE: begin
          cval[1]        = 1'b1;
          cand[1].kind   = pts_pkg::KIND_BAD;
          cand[1].start  = p;
          cand[1].length = 32'd1;
          m = pts_pkg::MODE_DEAD;
          d = '0;
        end
        default: begin
          m = pts_pkg::is_num(data_byte) ? pts_pkg::MODE_NUMBER : pts_pkg::MODE_KEYWORD;
        end
      endcase
    end

    if (end_of_input && m != pts_pkg::MODE_DEAD) begin
      cand[2].start  = s;
      cand[2].length = q - s;
      case (m)
        pts_pkg::MODE_NAME: begin
          cval[2] = 1'b1;
          cand[2].kind = pts_pkg::KIND_NAME;
        end
        pts_pkg::MODE_KEYWORD: begin
          cval[2] = 1'b1;
          cand[2].kind = pts_pkg::KIND_KEYWORD;
        end
        pts_pkg::MODE_NUMBER: begin
          cval[2] = 1'b1;
          cand[2].kind = pts_pkg::KIND_NUMBER;
        end
        pts_pkg::MODE_STRING, pts_pkg::MODE_ESCAPE: begin
          cval[2] = 1'b1;
          cand[2].kind = pts_pkg::KIND_STRING;
        end
        pts_pkg::MODE_HEX: begin
          cval[2] = 1'b1;
          cand[2].kind = pts_pkg::KIND_HEX;
        end
        pts_pkg::MODE_LT, pts_pkg::MODE_GT: begin
          cval[2] = 1'b1;
          cand[2].kind   = pts_pkg::KIND_BAD;
          cand[2].length = 32'd1;
          m = pts_pkg::MODE_DEAD;
          d = '0;
        end
        default: begin
        end
      endcase
      if (m != pts_pkg::MODE_DEAD) begin
        cval[3]        = 1'b1;
        cand[3].kind   = pts_pkg::KIND_END;
        cand[3].start  = q;
        cand[3].length = 32'd0;
        m  = pts_pkg::MODE_IDLE;
        d  = '0;
        np = '0;
        s  = '0;
      end
    end

    n   = '0;
    res = '0;
    for (int k = 0; k < 4; k++) begin
      if (cval[k] && n < pts_pkg::RCNT_W'(pts_pkg::MAX_RES)) begin
        res[n[1:0]] = cand[k];
        n = n + 1'b1;
      end
    end
    if (n != '0) begin
      res[2'(n - 1'b1)].last = 1'b1;
    end
    res_cnt = n;

    state_out.mode  = m;
    state_out.depth = d;
    state_out.pos   = np;
    state_out.start = s;
  end

endmodule

`default_nettype wire

// ===== sv/pdf_token_scanner_core.sv =====
// PDF token scanner top level: scanner state registers, step logic and a result queue.
// A byte's first record is offered on the output in the cycle after its transaction when the queue is empty.
// Throughput: one byte per cycle while each byte yields at most one record and out_tready
// is high; a byte may yield up to three, and records leave a four-entry queue at one
// per cycle, so in_tready is low while more than one record is queued.
// Reset: synchronous, active low; clears the scanner state and empties the queue.
`default_nettype none

module pdf_token_scanner_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // data_byte
  input  wire logic        in_tlast,   // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // token_start [31:0], token_length [63:32]
  output logic [3:0]       out_tuser,  // token_kind
  output logic             out_tlast   // last_result
);

  pts_pkg::scan_state_t                    state_r, state_nxt, step_state;
  pts_pkg::result_t [pts_pkg::MAX_RES-1:0] step_res;
  logic [pts_pkg::RCNT_W-1:0]              step_cnt;
  pts_pkg::result_t                        q_r [pts_pkg::QUEUE_DEPTH];
  pts_pkg::result_t                        q_nxt [pts_pkg::QUEUE_DEPTH];
  pts_pkg::result_t                        q_sh [pts_pkg::QUEUE_DEPTH];
  logic [pts_pkg::QCNT_W-1:0]              cnt_r, cnt_nxt, base;
  logic [pts_pkg::QCNT_W-1:0]              off;
  logic                                    push, pop;

  pts_step u_step (
    .state_in     (state_r),
    .data_byte    (in_tdata),
    .end_of_input (in_tlast),
    .state_out    (step_state),
    .res          (step_res),
    .res_cnt      (step_cnt)
  );

  assign in_tready  = (cnt_r <= pts_pkg::QCNT_W'(1));
  assign push       = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign out_tdata  = {q_r[0].length, q_r[0].start};
  assign out_tuser  = q_r[0].kind;
  assign out_tlast  = q_r[0].last;
  assign state_nxt  = push ? step_state : state_r;

  always_comb begin
    for (int i = 0; i < pts_pkg::QUEUE_DEPTH - 1; i++) begin
      q_sh[i] = pop ? q_r[i + 1] : q_r[i];
    end
    q_sh[pts_pkg::QUEUE_DEPTH - 1] = q_r[pts_pkg::QUEUE_DEPTH - 1];
    base = cnt_r - pts_pkg::QCNT_W'(pop);
    off  = '0;
    for (int i = 0; i < pts_pkg::QUEUE_DEPTH; i++) begin
      q_nxt[i] = q_sh[i];
      off = pts_pkg::QCNT_W'(i) - base;
      if (push && pts_pkg::QCNT_W'(i) >= base &&
          off < pts_pkg::QCNT_W'(step_cnt)) begin
        q_nxt[i] = step_res[off[1:0]];
      end
    end
    cnt_nxt = base + (push ? pts_pkg::QCNT_W'(step_cnt) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{mode: pts_pkg::MODE_IDLE, depth: '0, pos: '0, start: '0};
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= pts_pkg::QCNT_W'(pts_pkg::QUEUE_DEPTH))
    else $error("Result queue count exceeds its depth.");

  a_group_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (cnt_r >= pts_pkg::QCNT_W'(2)))
    else $error("A record group was queued only in part.");

  a_dead_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == pts_pkg::MODE_DEAD) |=> (state_r.mode == pts_pkg::MODE_DEAD))
    else $error("Scanner left the dead state without reset.");

  a_depth_in_string: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.depth != '0) |->
      (state_r.mode == pts_pkg::MODE_STRING || state_r.mode == pts_pkg::MODE_ESCAPE))
    else $error("Nesting depth held outside a string.");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && q_r[0].kind == pts_pkg::KIND_END) |-> out_tlast)
    else $error("End record is not the last of its group.");

endmodule

`default_nettype wire
